// File: rtl/cpfp_pkg.sv
// ============================================================================
// cpfp_pkg - shared types and constants of the position frame parser
// Widths, register indexes, reset values and the frame record that travels
// from the byte front end through the queue to the scaling back end.
// ============================================================================
package cpfp_pkg;

    // Serial byte and frame window.
    localparam int BYTE_W  = 8;
    localparam int WIN_LEN = 6;
    localparam int FILL_W  = $clog2(WIN_LEN);

    // Configuration fields.
    localparam int HDR_W    = 8;
    localparam int OFFSET_W = 20;
    localparam int GAIN_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(2);

    localparam logic [HDR_W-1:0]    HEADER_RST = HDR_W'(172);
    localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(200000);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(200);

    // Result fields.
    localparam int RAW_W  = 16;
    localparam int PROD_W = GAIN_W + RAW_W;
    localparam int POSX_W = 26;
    localparam int POSY_W = 27;
    localparam int SUM_W  = 27;
    localparam int OUT_BITS   = POSX_W + POSY_W + 2 * RAW_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Queue between front end and back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_x;
    } t_frame;

endpackage

// File: rtl/cpfp_front.sv
// ============================================================================
// cpfp_front - byte window and frame check
// Collects received bytes in a six byte window and, when it fills, checks
// the header and the checksum, then either forwards the frame or slides.
// ============================================================================
module cpfp_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_byte_vld,
    output logic                              o_byte_rdy,
    input  logic [cpfp_pkg::BYTE_W-1:0]       i_byte,
    input  logic [cpfp_pkg::HDR_W-1:0]        i_header,
    output logic                              o_push,
    output cpfp_pkg::t_frame                  o_frame,
    input  logic                              i_q_full
);

    logic [cpfp_pkg::BYTE_W-1:0] r_win [cpfp_pkg::WIN_LEN-1];
    logic [cpfp_pkg::FILL_W-1:0] r_fill;
    logic [cpfp_pkg::FILL_W-1:0] n_fill;
    logic                        w_accept;
    logic                        w_last;
    logic                        w_good;
    logic [cpfp_pkg::BYTE_W-1:0] w_sum;

    assign o_byte_rdy = !i_q_full;
    assign w_accept   = i_byte_vld && o_byte_rdy;
    assign w_last     = (r_fill == cpfp_pkg::FILL_W'(cpfp_pkg::WIN_LEN - 1));
    assign w_sum      = r_win[1] + r_win[2] + r_win[3] + r_win[4];
    assign w_good     = (r_win[0] == i_header) && (w_sum == i_byte);

    assign o_push  = w_accept && w_last && w_good;
    assign o_frame = '{raw_y: {r_win[4], r_win[3]}, raw_x: {r_win[2], r_win[1]}};

    always_comb begin
        if (!w_last) begin
            n_fill = r_fill + cpfp_pkg::FILL_W'(1);
        end else if (w_good) begin
            n_fill = '0;
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    // Window contents carry no reset; only filled entries are ever read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!w_last) begin
                r_win[r_fill] <= i_byte;
            end else if (!w_good) begin
                for (int i = 0; i < cpfp_pkg::WIN_LEN - 2; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[cpfp_pkg::WIN_LEN-2] <= i_byte;
            end
        end
    end

endmodule

// File: rtl/cpfp_queue.sv
// ============================================================================
// cpfp_queue - short frame queue
// A small register FIFO that lets the front end and back end stall apart.
// ============================================================================
module cpfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cpfp_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output cpfp_pkg::t_frame o_frame
);

    cpfp_pkg::t_frame            r_mem [cpfp_pkg::Q_DEPTH];
    logic [cpfp_pkg::Q_AW-1:0]   r_wr_ptr;
    logic [cpfp_pkg::Q_AW-1:0]   r_rd_ptr;
    logic [cpfp_pkg::Q_CW-1:0]   r_count;
    logic [cpfp_pkg::Q_AW-1:0]   n_wr_ptr;
    logic [cpfp_pkg::Q_AW-1:0]   n_rd_ptr;
    logic [cpfp_pkg::Q_CW-1:0]   n_count;

    assign o_full  = (r_count == cpfp_pkg::Q_CW'(cpfp_pkg::Q_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == cpfp_pkg::Q_AW'(cpfp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + cpfp_pkg::Q_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == cpfp_pkg::Q_AW'(cpfp_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + cpfp_pkg::Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + cpfp_pkg::Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - cpfp_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// File: rtl/cpfp_back.sv
// ============================================================================
// cpfp_back - coordinate scaling
// Two stage pipeline: gain multiply, then offset add, saturation and the
// sign of y, ending in the output register.
// ============================================================================
module cpfp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_vld,
    input  cpfp_pkg::t_frame                  i_frame,
    output logic                              o_pop,
    input  logic [cpfp_pkg::OFFSET_W-1:0]     i_offset,
    input  logic [cpfp_pkg::GAIN_W-1:0]       i_gain,
    output logic                              o_vld,
    input  logic                              i_rdy,
    output logic [cpfp_pkg::POSX_W-1:0]       o_pos_x,
    output logic signed [cpfp_pkg::POSY_W-1:0] o_pos_y,
    output cpfp_pkg::t_frame                  o_raw
);

    localparam logic [cpfp_pkg::SUM_W-1:0] Y_MAG_MAX =
        cpfp_pkg::SUM_W'(1) << cpfp_pkg::POSX_W;

    logic                          r_s1_vld;
    logic [cpfp_pkg::PROD_W-1:0]   r_s1_prod_x;
    logic [cpfp_pkg::PROD_W-1:0]   r_s1_prod_y;
    cpfp_pkg::t_frame              r_s1_raw;
    logic                          r_out_vld;
    logic                          w_out_load;
    logic [cpfp_pkg::SUM_W-1:0]    w_sum_x;
    logic [cpfp_pkg::SUM_W-1:0]    w_sum_y;
    logic [cpfp_pkg::POSX_W-1:0]   w_pos_x;
    logic [cpfp_pkg::SUM_W-1:0]    w_mag_y;

    assign w_out_load = r_s1_vld && (!r_out_vld || i_rdy);
    assign o_pop      = i_q_vld && (!r_s1_vld || w_out_load);
    assign o_vld      = r_out_vld;

    assign w_sum_x = cpfp_pkg::SUM_W'(i_offset) + cpfp_pkg::SUM_W'(r_s1_prod_x);
    assign w_sum_y = cpfp_pkg::SUM_W'(i_offset) + cpfp_pkg::SUM_W'(r_s1_prod_y);
    // The sum never exceeds 27 bits, so bit 26 alone flags x overflow.
    assign w_pos_x = w_sum_x[cpfp_pkg::POSX_W] ? '1 : w_sum_x[cpfp_pkg::POSX_W-1:0];
    assign w_mag_y = (w_sum_y > Y_MAG_MAX) ? Y_MAG_MAX : w_sum_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_vld <= 1'b1;
            end else if (w_out_load) begin
                r_s1_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod_x <= cpfp_pkg::PROD_W'(i_gain) * cpfp_pkg::PROD_W'(i_frame.raw_x);
            r_s1_prod_y <= cpfp_pkg::PROD_W'(i_gain) * cpfp_pkg::PROD_W'(i_frame.raw_y);
            r_s1_raw    <= i_frame;
        end
        if (w_out_load) begin
            o_pos_x <= w_pos_x;
            o_pos_y <= signed'(cpfp_pkg::POSY_W'(cpfp_pkg::SUM_W'(0) - w_mag_y));
            o_raw   <= r_s1_raw;
        end
    end

endmodule

// File: rtl/checksummed_position_frame_parser_core.sv
// ============================================================================
// checksummed_position_frame_parser_core - serial position frame parser
// Finds checksummed position frames in a byte stream and delivers scaled
// and raw coordinates.
// ============================================================================
//
//  Channel   | Direction | Transfer when           | Payload
//  ----------+-----------+-------------------------+----------------------------
//  s_axis    | in        | s_axis_tvalid & tready  | one received byte
//  m_axis    | out       | m_axis_tvalid & tready  | scaled and raw coordinates
//  cfg       | in        | i_cfg_valid & o_cfg_ready | register index and value
//
//  One byte is transferred per cycle; the byte input stalls only when the
//  two-entry frame queue between the byte front end and the scaling pipeline
//  is full. A good frame's checksum byte pushes it into the queue; it then
//  passes the gain multiplier register and, after the offset adder, the
//  output register, and stalls can hold it. Reset is synchronous and active
//  low; it empties window, queue and pipeline and restores register defaults.
//
module checksummed_position_frame_parser_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Byte input.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [7:0] rx_byte
    input  logic [cpfp_pkg::BYTE_W-1:0]         s_axis_tdata,
    // Result output.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [25:0] pos_x_milli, [52:26] pos_y_milli, [68:53] raw_x_value,
    //        [84:69] raw_y_value, [87:85] zero
    output logic [cpfp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpfp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [cpfp_pkg::HDR_W-1:0]     r_header;
    logic [cpfp_pkg::OFFSET_W-1:0]  r_offset;
    logic [cpfp_pkg::GAIN_W-1:0]    r_gain;

    logic                           w_push;
    cpfp_pkg::t_frame               w_push_frame;
    logic                           w_q_full;
    logic                           w_q_vld;
    logic                           w_pop;
    cpfp_pkg::t_frame               w_q_frame;
    logic [cpfp_pkg::POSX_W-1:0]    w_pos_x;
    logic signed [cpfp_pkg::POSY_W-1:0] w_pos_y;
    cpfp_pkg::t_frame               w_raw;

    // The register file is always ready; writes to unused indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= cpfp_pkg::HEADER_RST;
            r_offset <= cpfp_pkg::OFFSET_RST;
            r_gain   <= cpfp_pkg::GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cpfp_pkg::REG_HEADER: r_header <= i_cfg_data[cpfp_pkg::HDR_W-1:0];
                cpfp_pkg::REG_OFFSET: r_offset <= i_cfg_data[cpfp_pkg::OFFSET_W-1:0];
                cpfp_pkg::REG_GAIN:   r_gain   <= i_cfg_data[cpfp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: window, header and checksum check.
    cpfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (s_axis_tvalid),
        .o_byte_rdy (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_header   (r_header),
        .o_push     (w_push),
        .o_frame    (w_push_frame),
        .i_q_full   (w_q_full)
    );

    // Good frames wait here until the scaling pipeline takes them.
    cpfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_frame (w_q_frame)
    );

    // Back end: scaling, saturation and the output register.
    cpfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (w_q_vld),
        .i_frame  (w_q_frame),
        .o_pop    (w_pop),
        .i_offset (r_offset),
        .i_gain   (r_gain),
        .o_vld    (m_axis_tvalid),
        .i_rdy    (m_axis_tready),
        .o_pos_x  (w_pos_x),
        .o_pos_y  (w_pos_y),
        .o_raw    (w_raw)
    );

    assign m_axis_tdata = {
        (cpfp_pkg::OUT_DATA_W - cpfp_pkg::OUT_BITS)'(0),
        w_raw.raw_y,
        w_raw.raw_x,
        w_pos_y,
        w_pos_x
    };

endmodule

// File: rtl/cpfp_checker.sv
// ============================================================================
// cpfp_checker - port level checks of the position frame parser
// Watches the top level ports and flags slips in reset, stalls, the sign
// of the y coordinate and the pad bits.
// ============================================================================
module cpfp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [cpfp_pkg::BYTE_W-1:0]     s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [cpfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [cpfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpfp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int Y_LO = cpfp_pkg::POSX_W;
    localparam int Y_HI = cpfp_pkg::POSX_W + cpfp_pkg::POSY_W - 1;

    // Reset empties the pipeline and the queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input stall after reset");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // The y coordinate is never positive.
    a_y_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[Y_HI] || (m_axis_tdata[Y_HI:Y_LO] == '0))
        else $error("positive y coordinate");

    // The pad bits above the packed fields stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[cpfp_pkg::OUT_DATA_W-1:cpfp_pkg::OUT_BITS] == '0)
        else $error("non-zero pad bits in result");

endmodule

bind checksummed_position_frame_parser_core cpfp_checker u_cpfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);
